// ===== src/ssmd_pkg.sv =====
package ssmd_pkg;

  localparam int OPCODE_W = 4;
  localparam int DIGIT_W  = 2;
  localparam int VALUE_W  = 8;
  localparam int SEG_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [OPCODE_W-1:0] OP_TICK       = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE_CHAR = 4'd1;
  localparam logic [OPCODE_W-1:0] OP_DOT_SET    = 4'd2;
  localparam logic [OPCODE_W-1:0] OP_DOT_CLEAR  = 4'd3;
  localparam logic [OPCODE_W-1:0] OP_CLEAR      = 4'd4;
  localparam logic [OPCODE_W-1:0] OP_ENABLE     = 4'd5;
  localparam logic [OPCODE_W-1:0] OP_DISABLE    = 4'd6;
  localparam logic [OPCODE_W-1:0] OP_BRIGHTNESS = 4'd7;
  localparam logic [OPCODE_W-1:0] OP_MODE       = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_REFRESH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD      = 1'd1;

  localparam logic [7:0]  TICKS_PER_REFRESH_RESET = 8'd1;
  localparam logic [15:0] BLINK_PERIOD_RESET      = 16'd600;

  localparam logic [SEG_W-1:0] DOT_BIT    = 8'h80;
  localparam logic [7:0]       FIRST_CHAR = 8'h2D;
  localparam logic [7:0]       LAST_CHAR  = 8'h7A;
  localparam int               GLYPH_COUNT = 78;

  localparam logic [SEG_W-1:0] GLYPH_TABLE [GLYPH_COUNT] = '{
    8'h40, 8'h00, 8'h00,
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h77, 8'h00, 8'h39, 8'h00, 8'h79, 8'h71, 8'h3D,
    8'h76, 8'h30, 8'h1E, 8'h00, 8'h38, 8'h00, 8'h00, 8'h3F, 8'h73, 8'h00, 8'h00, 8'h6D,
    8'h00, 8'h3E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08,
    8'h00, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h00, 8'h00, 8'h00, 8'h74, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h54, 8'h5C, 8'h00, 8'h67, 8'h50, 8'h00, 8'h78, 8'h1C, 8'h00, 8'h00,
    8'h00, 8'h6E, 8'h00
  };

  typedef struct packed {
    logic [SEG_W-1:0]   segments;
    logic [DIGIT_W-1:0] digit_select;
    logic               refreshed;
  } result_t;

  function automatic logic [SEG_W-1:0] decode_char(input logic [7:0] c);
    logic [7:0] off;
    off = c - FIRST_CHAR;
    if (c < FIRST_CHAR || c > LAST_CHAR) begin
      return '0;
    end
    return GLYPH_TABLE[off[6:0]];
  endfunction

endpackage

// ===== src/ssmd_if.sv =====
interface ssmd_in_if;
  logic                           valid;
  logic                           ready;
  logic [ssmd_pkg::OPCODE_W-1:0]  opcode;
  logic [ssmd_pkg::DIGIT_W-1:0]   digit;
  logic [ssmd_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output opcode, output digit, output value, input ready);
  modport sink   (input valid, input opcode, input digit, input value, output ready);
endinterface

interface ssmd_out_if;
  logic                          valid;
  logic                          ready;
  logic [ssmd_pkg::SEG_W-1:0]    segments;
  logic [ssmd_pkg::DIGIT_W-1:0]  digit_select;
  logic                          refreshed;

  modport source (output valid, output segments, output digit_select, output refreshed,
                  input ready);
  modport sink   (input valid, input segments, input digit_select, input refreshed,
                  output ready);
endinterface

// ===== src/seven_segment_mux_driver_core.sv =====
// channel   dir  handshake     payload
// cmd       in   valid/ready   opcode[3:0], digit[1:0], value[7:0]
// res       out  valid/ready   segments[7:0], digit_select[1:0], refreshed
// cfg       in   cfg_we        cfg_index[0], cfg_data[15:0]
//
// one request per cycle while cmd ready is high; each request updates the display state in
// the cycle it is taken and its result is registered into the result queue
// the rate is set by the combinational state update feeding a two-entry result queue
// rst is synchronous: all registers but the two result slots return to power-up values
// when res stalls, up to two results queue before cmd ready drops
module seven_segment_mux_driver_core #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  ssmd_in_if.sink                           cmd,
  ssmd_out_if.source                        res,
  input  logic                              cfg_we,
  input  logic [ssmd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssmd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [7:0]  ticks_per_refresh;
  logic [15:0] blink_period;

  logic [7:0]  tick_counter, tick_counter_next;
  logic [1:0]  digit_pointer, digit_pointer_next;
  logic [15:0] blink_counter, blink_counter_next;
  logic [7:0]  segment_hold, segment_hold_next;
  logic [1:0]  select_hold, select_hold_next;

  logic [7:0] glyph_store          [DIGIT_COUNT];
  logic [7:0] glyph_store_next     [DIGIT_COUNT];
  logic [7:0] brightness_level     [DIGIT_COUNT];
  logic [7:0] brightness_level_next[DIGIT_COUNT];
  logic [7:0] brightness_countdown [DIGIT_COUNT];
  logic [7:0] brightness_countdown_next [DIGIT_COUNT];
  logic [DIGIT_COUNT-1:0] blink_mode, blink_mode_next;
  logic [DIGIT_COUNT-1:0] digit_enabled, digit_enabled_next;
  logic [DIGIT_COUNT-1:0] blink_phase, blink_phase_next;

  logic [1:0] cnt, cnt_next;
  ssmd_pkg::result_t slot0, slot1, push_data;

  logic accept, pop, is_tick, do_refresh, cmd_hit, blink_wrap;
  logic [1:0] ptr_eff;

  assign accept = cmd.valid && cmd.ready;
  assign pop    = res.valid && res.ready;
  assign cmd.ready = (cnt != 2'd2);
  assign res.valid = (cnt != 2'd0);
  assign res.segments     = slot0.segments;
  assign res.digit_select = slot0.digit_select;
  assign res.refreshed    = slot0.refreshed;

  assign is_tick    = (cmd.opcode == ssmd_pkg::OP_TICK);
  assign do_refresh = accept && is_tick && (tick_counter == ticks_per_refresh);
  assign cmd_hit    = accept && !is_tick && (int'(cmd.digit) < DIGIT_COUNT);
  assign ptr_eff    = (int'(digit_pointer) >= DIGIT_COUNT) ? 2'd0 : digit_pointer;
  assign blink_wrap = (blink_counter == blink_period);

  always_comb begin
    tick_counter_next  = tick_counter;
    digit_pointer_next = digit_pointer;
    blink_counter_next = blink_counter;
    segment_hold_next  = segment_hold;
    select_hold_next   = select_hold;
    blink_mode_next    = blink_mode;
    digit_enabled_next = digit_enabled;
    blink_phase_next   = blink_phase;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      glyph_store_next[i]          = glyph_store[i];
      brightness_level_next[i]     = brightness_level[i];
      brightness_countdown_next[i] = brightness_countdown[i];
    end

    if (accept && is_tick) begin
      if (do_refresh) begin
        segment_hold_next  = '0;
        select_hold_next   = ptr_eff;
        blink_counter_next = blink_wrap ? 16'd0 : blink_counter + 16'd1;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          if (blink_wrap && blink_mode[i]) begin
            blink_phase_next[i] = !blink_phase[i];
          end
          if (ptr_eff == 2'(i)) begin
            if (brightness_countdown[i] == 8'd0) begin
              if (digit_enabled[i] && (blink_phase_next[i] || !blink_mode[i])) begin
                segment_hold_next            = glyph_store[i];
                brightness_countdown_next[i] = brightness_level[i];
              end
            end else begin
              brightness_countdown_next[i] = brightness_countdown[i] - 8'd1;
            end
          end
        end
        digit_pointer_next = ptr_eff + 2'd1;
        tick_counter_next  = 8'd1;
      end else begin
        tick_counter_next = tick_counter + 8'd1;
      end
    end

    if (cmd_hit) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        if (cmd.digit == 2'(i)) begin
          unique case (cmd.opcode)
            ssmd_pkg::OP_WRITE_CHAR: glyph_store_next[i] =
                ssmd_pkg::decode_char(cmd.value) | (glyph_store[i] & ssmd_pkg::DOT_BIT);
            ssmd_pkg::OP_DOT_SET:    glyph_store_next[i] = glyph_store[i] | ssmd_pkg::DOT_BIT;
            ssmd_pkg::OP_DOT_CLEAR:  glyph_store_next[i] = glyph_store[i] & ~ssmd_pkg::DOT_BIT;
            ssmd_pkg::OP_CLEAR:      glyph_store_next[i] = '0;
            ssmd_pkg::OP_ENABLE:     digit_enabled_next[i] = 1'b1;
            ssmd_pkg::OP_DISABLE:    digit_enabled_next[i] = 1'b0;
            ssmd_pkg::OP_BRIGHTNESS: brightness_level_next[i] = cmd.value;
            ssmd_pkg::OP_MODE:       blink_mode_next[i] = cmd.value[0];
            default: ;
          endcase
        end
      end
    end

    push_data.segments     = segment_hold_next;
    push_data.digit_select = select_hold_next;
    push_data.refreshed    = do_refresh;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_refresh <= ssmd_pkg::TICKS_PER_REFRESH_RESET;
      blink_period      <= ssmd_pkg::BLINK_PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssmd_pkg::CFG_TICKS_PER_REFRESH: ticks_per_refresh <= cfg_data[7:0];
        ssmd_pkg::CFG_BLINK_PERIOD:      blink_period      <= cfg_data;
        default: ;
      endcase
    end
  end

  // display state
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter  <= 8'd1;
      digit_pointer <= '0;
      blink_counter <= '0;
      segment_hold  <= '0;
      select_hold   <= '0;
      blink_mode    <= '0;
      digit_enabled <= '1;
      blink_phase   <= '1;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        glyph_store[i]          <= '0;
        brightness_level[i]     <= '0;
        brightness_countdown[i] <= '0;
      end
    end else begin
      tick_counter  <= tick_counter_next;
      digit_pointer <= digit_pointer_next;
      blink_counter <= blink_counter_next;
      segment_hold  <= segment_hold_next;
      select_hold   <= select_hold_next;
      blink_mode    <= blink_mode_next;
      digit_enabled <= digit_enabled_next;
      blink_phase   <= blink_phase_next;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        glyph_store[i]          <= glyph_store_next[i];
        brightness_level[i]     <= brightness_level_next[i];
        brightness_countdown[i] <= brightness_countdown_next[i];
      end
    end
  end

  // result queue
  always_comb begin
    cnt_next = cnt + {1'b0, accept} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt == 2'd2) begin
        slot0 <= slot1;
      end else if (accept) begin
        slot0 <= push_data;
      end
    end else if (accept) begin
      if (cnt == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end
  end

  a_refresh_restarts_count: assert property (@(posedge clk) disable iff (rst)
    do_refresh |=> tick_counter == 8'd1)
    else $error("tick counter not restarted after refresh");

  a_select_in_range: assert property (@(posedge clk) disable iff (rst)
    do_refresh |=> int'(select_hold) < DIGIT_COUNT)
    else $error("refresh selected a digit beyond the row");

  a_command_holds_segments: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_tick) |=> $stable(segment_hold) && $stable(select_hold))
    else $error("command request changed the driven segments");

  a_full_queue_holds: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !res.ready) |=> cnt == 2'd2 && $stable(slot0))
    else $error("stalled result queue lost or changed its head");

endmodule
